// ===== sv/mctb_pkg.sv =====
`default_nettype none

package mctb_pkg;

  localparam int TIMER_SLOTS_DEF = 8;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 3;
  localparam int CNT_W32   = 32;
  localparam int INC_W     = 16;
  localparam int TIU_W     = 4;
  localparam int MASK_W    = 8;
  localparam int MASK_AW   = 3;
  localparam int STATE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIU      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENDLESS  = 2'd2;

  localparam logic [INC_W-1:0]   TICK_INC_RST = 16'd1;
  localparam logic [TIU_W-1:0]   TIU_RST      = 4'd0;
  localparam logic [CNT_W32-1:0] ENDLESS_RST  = 32'd0;

  typedef enum logic [STATE_W-1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PAUSED  = 2'd2,
    ST_ELAPSED = 2'd3
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_RESTART = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_RESUME  = 3'd5,
    OP_QUERY   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMD  = 2'd1,
    FSM_TICK = 2'd2,
    FSM_RESP = 2'd3
  } fsm_t;

  typedef struct packed {
    status_t              status;
    logic [CNT_W32-1:0]   count;
    logic [CNT_W32-1:0]   target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{status: ST_STOPPED, count: '0, target: '0};

endpackage

`default_nettype wire

// ===== sv/mctb_in_if.sv =====
`default_nettype none

interface mctb_in_if;
  import mctb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [IDX_W-1:0]     timer_index;
  logic [CNT_W32-1:0]   new_target;

  modport source (output valid, output operation, output timer_index, output new_target,
                  input ready);
  modport sink   (input valid, input operation, input timer_index, input new_target,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/mctb_out_if.sv =====
`default_nettype none

interface mctb_out_if;
  import mctb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   timer_state;
  logic [CNT_W32-1:0]   current_count;
  logic                 elapsed_flag;
  logic [MASK_W-1:0]    elapsed_mask;
  logic                 index_error;

  modport source (output valid, output timer_state, output current_count,
                  output elapsed_flag, output elapsed_mask, output index_error,
                  input ready);
  modport sink   (input valid, input timer_state, input current_count,
                  input elapsed_flag, input elapsed_mask, input index_error,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/mctb_cfg_if.sv =====
`default_nettype none

interface mctb_cfg_if;
  import mctb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_index;
  logic [CFG_DAT_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/mctb_ram.sv =====
`default_nettype none

module mctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/mctb_update.sv =====
`default_nettype none

module mctb_update (
  input  logic                         tick,
  input  mctb_pkg::op_t                op,
  input  logic [mctb_pkg::CNT_W32-1:0] new_target,
  input  logic [mctb_pkg::INC_W-1:0]   tick_inc,
  input  logic [mctb_pkg::CNT_W32-1:0] endless,
  input  mctb_pkg::entry_t             cur,
  output mctb_pkg::entry_t             upd,
  output logic                         changed,
  output logic                         elapsed
);
  import mctb_pkg::*;

  logic [CNT_W32-1:0] sum;

  assign sum = cur.count + CNT_W32'(tick_inc);

  always_comb begin
    upd     = cur;
    changed = 1'b0;
    elapsed = 1'b0;
    if (tick) begin
      if (cur.status == ST_RUNNING) begin
        changed = 1'b1;
        if ((sum >= cur.target) && (cur.target != endless)) begin
          upd.status = ST_ELAPSED;
          upd.count  = '0;
          elapsed    = 1'b1;
        end else begin
          upd.count = sum;
        end
      end
    end else begin
      unique case (op)
        OP_SET: begin
          upd.target = new_target;
          upd.status = ST_RUNNING;
          changed    = 1'b1;
        end
        OP_RESTART: begin
          upd.target = new_target;
          upd.status = ST_RUNNING;
          upd.count  = '0;
          changed    = 1'b1;
        end
        OP_CLEAR: begin
          upd.count  = '0;
          upd.status = ST_STOPPED;
          changed    = 1'b1;
        end
        OP_PAUSE: begin
          upd.status = ST_PAUSED;
          changed    = 1'b1;
        end
        OP_RESUME: begin
          upd.status = ST_RUNNING;
          changed    = 1'b1;
        end
        default: begin
          // query and the unused code read the entry only
          changed = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_channel_soft_timer_bank.sv =====
`default_nettype none

// Channel  | Dir | Word
// ---------+-----+-------------------------------------------------------------
// in_chan  | in  | operation, timer_index, new_target
// out_chan | out | timer_state, current_count, elapsed_flag, elapsed_mask,
//          |     | index_error
// cfg_chan | in  | reg_index, wdata (always ready)
//
// A command word goes through one RAM read, one modify-and-write and one result
// hand-over until its result register is loaded.
// A tick word sweeps the N slots in use: the sweep reads,
// updates and writes back one slot per cycle through the single timer RAM.
// Reset is synchronous and active low; the timer RAM is not cleared, a valid
// bit per slot makes an unwritten slot read as stopped with zero count/target.
// A waiting result in the output register does not stop the next word being
// accepted; only a second finished result stalls until the first is taken.

module multi_channel_soft_timer_bank #(
  parameter int TIMER_SLOTS = mctb_pkg::TIMER_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mctb_in_if.sink    in_chan,
  mctb_out_if.source out_chan,
  mctb_cfg_if.sink   cfg_chan
);
  import mctb_pkg::*;

  localparam int SLOT_AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int ACT_W   = SLOT_AW + 1;

  // Configuration registers
  logic [INC_W-1:0]   inc_r;
  logic [TIU_W-1:0]   tiu_r;
  logic [CNT_W32-1:0] endless_r;

  // Sequencer
  fsm_t               state_r, state_nxt;
  logic [SLOT_AW-1:0] cnt_r, cnt_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;

  // Captured command word
  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W32-1:0] tgt_r;

  // Pending result
  status_t            res_state_r, res_state_nxt;
  logic [CNT_W32-1:0] res_count_r, res_count_nxt;
  logic               res_flag_r, res_flag_nxt;
  logic               res_err_r, res_err_nxt;

  // Output register
  logic               out_vld_r;
  status_t            out_state_r;
  logic [CNT_W32-1:0] out_count_r;
  logic               out_flag_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic               out_err_r;

  // Timer RAM and per-slot valid bits
  logic                 ram_we;
  logic [SLOT_AW-1:0]   ram_waddr;
  logic [SLOT_AW-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [TIMER_SLOTS-1:0] vld_r;
  logic                 rd_vld_r;
  entry_t               rd_entry;
  entry_t               upd_entry;
  logic                 upd_changed;
  logic                 upd_elapsed;

  logic               in_fire;
  logic               out_load;
  logic [ACT_W-1:0]   active_n;
  logic               idx_err;
  logic [SLOT_AW-1:0] idx_addr;
  logic [MASK_AW-1:0] bit_sel;
  logic               sweep_last;

  // Slots in use, clamped to what the RAM holds
  assign active_n = (32'(tiu_r) > 32'(TIMER_SLOTS)) ? ACT_W'(TIMER_SLOTS) : ACT_W'(tiu_r);
  assign idx_err  = 32'(idx_r) >= 32'(active_n);
  assign idx_addr = SLOT_AW'(idx_r);
  assign bit_sel  = MASK_AW'(cnt_r);
  assign sweep_last = (({1'b0, cnt_r} + ACT_W'(1)) == active_n);

  assign in_chan.ready  = (state_r == FSM_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_load       = (state_r == FSM_RESP) && (!out_vld_r || out_chan.ready);

  assign out_chan.valid         = out_vld_r;
  assign out_chan.timer_state   = out_state_r;
  assign out_chan.current_count = out_count_r;
  assign out_chan.elapsed_flag  = out_flag_r;
  assign out_chan.elapsed_mask  = out_mask_r;
  assign out_chan.index_error   = out_err_r;

  // An unwritten slot reads as its reset value
  assign rd_entry = rd_vld_r ? entry_t'(ram_rdata) : ENTRY_RESET;

  mctb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS),
    .AW    (SLOT_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(upd_entry)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mctb_update u_update (
    .tick       (state_r == FSM_TICK),
    .op         (op_r),
    .new_target (tgt_r),
    .tick_inc   (inc_r),
    .endless    (endless_r),
    .cur        (rd_entry),
    .upd        (upd_entry),
    .changed    (upd_changed),
    .elapsed    (upd_elapsed)
  );

  // Next state and RAM control. Reads and writes never meet on one slot:
  // a command writes its slot before the next word can be accepted, and the
  // sweep writes slot k while reading slot k + 1.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    res_state_nxt = res_state_r;
    res_count_nxt = res_count_r;
    res_flag_nxt  = res_flag_r;
    res_err_nxt   = res_err_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_raddr     = '0;
    unique case (state_r)
      FSM_IDLE: begin
        ram_raddr = (in_chan.operation == OP_TICK) ? '0 : SLOT_AW'(in_chan.timer_index);
        if (in_fire) begin
          if (in_chan.operation == OP_TICK) begin
            mask_nxt      = '0;
            cnt_nxt       = '0;
            res_state_nxt = ST_STOPPED;
            res_count_nxt = '0;
            res_flag_nxt  = 1'b0;
            res_err_nxt   = 1'b0;
            state_nxt     = (active_n == '0) ? FSM_RESP : FSM_TICK;
          end else begin
            state_nxt = FSM_CMD;
          end
        end
      end
      FSM_CMD: begin
        mask_nxt = '0;
        if (idx_err) begin
          res_state_nxt = ST_STOPPED;
          res_count_nxt = '0;
          res_flag_nxt  = 1'b0;
          res_err_nxt   = 1'b1;
        end else begin
          ram_we        = upd_changed;
          ram_waddr     = idx_addr;
          res_state_nxt = upd_entry.status;
          res_count_nxt = upd_entry.count;
          res_flag_nxt  = (upd_entry.status == ST_ELAPSED);
          res_err_nxt   = 1'b0;
        end
        state_nxt = FSM_RESP;
      end
      FSM_TICK: begin
        ram_raddr = cnt_r + SLOT_AW'(1);
        ram_we    = upd_changed;
        ram_waddr = cnt_r;
        if (upd_elapsed && (32'(cnt_r) < 32'(MASK_W))) begin
          mask_nxt[bit_sel] = 1'b1;
        end
        if (sweep_last) begin
          state_nxt = FSM_RESP;
        end else begin
          cnt_nxt = cnt_r + SLOT_AW'(1);
        end
      end
      FSM_RESP: begin
        if (out_load) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FSM_IDLE;
      inc_r     <= TICK_INC_RST;
      tiu_r     <= TIU_RST;
      endless_r <= ENDLESS_RST;
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Register writes, unknown indexes dropped
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.reg_index)
          REG_TICK_INC: inc_r     <= INC_W'(cfg_chan.wdata);
          REG_TIU:      tiu_r     <= TIU_W'(cfg_chan.wdata);
          REG_ENDLESS:  endless_r <= CNT_W32'(cfg_chan.wdata);
          default:      ;
        endcase
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      // Track validity alongside the registered RAM read
      rd_vld_r <= (32'(ram_raddr) < 32'(TIMER_SLOTS)) && vld_r[ram_raddr];
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    mask_r      <= mask_nxt;
    res_state_r <= res_state_nxt;
    res_count_r <= res_count_nxt;
    res_flag_r  <= res_flag_nxt;
    res_err_r   <= res_err_nxt;
    if (in_fire) begin
      op_r  <= op_t'(in_chan.operation);
      idx_r <= in_chan.timer_index;
      tgt_r <= in_chan.new_target;
    end
    if (out_load) begin
      out_state_r <= res_state_r;
      out_count_r <= res_count_r;
      out_flag_r  <= res_flag_r;
      out_mask_r  <= mask_r;
      out_err_r   <= res_err_r;
    end
  end

endmodule

`default_nettype wire
